// ===== rtl/core/bmff_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmff_pkg;

   // Default geometry of the map.
   localparam int DEFAULT_MAX_BITS  = 1024;
   localparam int DEFAULT_WORD_BITS = 64;

   // Configuration register indexes.
   localparam logic [0:0] CSR_BITS_IN_USE = 1'b0;
   localparam logic [0:0] CSR_START_CLEAR = 1'b1;

   // Operation codes of a request transaction.
   typedef enum logic [2:0] {
      OP_SET_BIT    = 3'd0,
      OP_CLEAR_BIT  = 3'd1,
      OP_FIND_CLEAR = 3'd2,
      OP_FIND_SET   = 3'd3,
      OP_REINIT     = 3'd4
   } op_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MODIFY = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_ENCODE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/allocation_bitmap_find_first_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Allocation bitmap with find-first search.
//
// The map holds MAX_BITS bits in words of WORD_BITS bits (a power of two); a stored
// one marks a free bit. A request transaction is taken when start is high and busy
// is low. It carries an operation code and a 1-based bit position: set bit, clear
// bit, find first clear, find first set, or reinit.
// Every request gives exactly one result transaction: rsp_valid is high for one
// cycle with rsp_found and rsp_bit_number. The receiver cannot stall the result,
// and a new request may be taken in the same cycle as a result is shown.
// Reinit, unknown codes, rejected positions and a find with no bits in use are
// answered straight from the idle state; set and clear do one memory read, then
// a write back. A find reads the words in order and, on a match, passes to the
// encode state; a find that reaches the bits in use with no match answers from
// the scan state. The single memory read port, one word a cycle, sets the find
// rate. One request is in flight at a time.
// Configuration transactions on the csr_ channel are always ready and are meant
// to be written while the block is idle.
// Reset marks every word as not yet written; such a word reads as the current
// fill value, so reset and reinit both take effect at once with no clearing pass.
module allocation_bitmap_find_first_unit
   import bmff_pkg::*;
#(
   parameter int MAX_BITS  = DEFAULT_MAX_BITS,
   parameter int WORD_BITS = DEFAULT_WORD_BITS,
   localparam int POS_W      = $clog2(MAX_BITS + 1),
   localparam int NWORDS     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS,
   localparam int IDX_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1,
   localparam int WORD_SHIFT = $clog2(WORD_BITS)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [2:0]       req_op,
   input  wire logic [POS_W-1:0] req_bit_position,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic      [POS_W-1:0] rsp_bit_number,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [0:0]       csr_addr,
   input  wire logic [POS_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [POS_W-1:0] bits_in_use_ff;
   logic             start_clear_ff;

   // Sequencer and working registers.
   state_type               state_ff, state_in;
   logic                    want_one_ff, want_one_in;
   logic                    set_op_ff, set_op_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic [WORD_SHIFT-1:0]   bit_ff, bit_in;
   logic [POS_W-1:0]        base_ff, base_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WORD_BITS-1:0]    match_ff, match_in;

   // Written flags per word and the value unwritten words read as.
   logic [NWORDS-1:0]       valid_ff, valid_in;
   logic                    fill_ff, fill_in;

   // Result registers.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_num_ff, rsp_num_in;

   // Memory port signals.
   logic                    wr_en;
   logic [WORD_BITS-1:0]    wr_data;
   logic [WORD_BITS-1:0]    ram_q;

   logic [POS_W-1:0]        eff_bits;
   logic [WORD_BITS-1:0]    word;
   logic [WORD_BITS-1:0]    iso;
   logic [WORD_SHIFT-1:0]   low_idx;
   logic [POS_W:0]          hit_pos;
   logic                    accept;

   bmff_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NWORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (addr_in),
      .rd_data (ram_q)
   );

   // Bits in use above the map size are clamped to the map size.
   assign eff_bits = (bits_in_use_ff > POS_W'(MAX_BITS)) ? POS_W'(MAX_BITS) : bits_in_use_ff;

   // The word just read, with unwritten words reading as the fill value.
   assign word = valid_ff[addr_ff] ? ram_q : {WORD_BITS{fill_ff}};

   // Lowest set bit of the stored match: isolate it, then encode it.
   always_comb begin
      iso     = match_ff & (~match_ff + WORD_BITS'(1));
      low_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         for (int b = 0; b < WORD_SHIFT; b++) begin
            if (i[b]) begin
               low_idx[b] = low_idx[b] | iso[i];
            end
         end
      end
      hit_pos = {1'b0, base_ff} + (POS_W+1)'(low_idx) + (POS_W+1)'(1);
   end

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      logic [POS_W-1:0]     p;
      logic [WORD_BITS-1:0] m;
      logic [POS_W:0]       next_base;
      logic [WORD_BITS-1:0] bit_mask;

      state_in     = state_ff;
      want_one_in  = want_one_ff;
      set_op_in    = set_op_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      base_in      = base_ff;
      pos_in       = pos_ff;
      match_in     = match_ff;
      valid_in     = valid_ff;
      fill_in      = fill_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_num_in   = '0;
      wr_en        = 1'b0;

      p         = req_bit_position - POS_W'(1);
      m         = want_one_ff ? word : ~word;
      next_base = {1'b0, base_ff} + (POS_W+1)'(WORD_BITS);
      bit_mask  = WORD_BITS'(1) << bit_ff;
      wr_data   = set_op_ff ? (word & ~bit_mask) : (word | bit_mask);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_SET_BIT, OP_CLEAR_BIT: begin
                     if ((req_bit_position != '0) && (req_bit_position <= eff_bits)) begin
                        set_op_in = (req_op == OP_SET_BIT);
                        addr_in   = IDX_W'(p >> WORD_SHIFT);
                        bit_in    = p[WORD_SHIFT-1:0];
                        pos_in    = req_bit_position;
                        state_in  = ST_MODIFY;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_FIND_CLEAR, OP_FIND_SET: begin
                     if (eff_bits != '0) begin
                        want_one_in = (req_op == OP_FIND_CLEAR);
                        addr_in     = '0;
                        base_in     = '0;
                        state_in    = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_REINIT: begin
                     valid_in     = '0;
                     fill_in      = start_clear_ff;
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            wr_en             = 1'b1;
            valid_in[addr_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_found_in      = 1'b1;
            rsp_num_in        = pos_ff;
            state_in          = ST_IDLE;
         end
         ST_SCAN: begin
            if (m != '0) begin
               match_in = m;
               state_in = ST_ENCODE;
            end else if (next_base < {1'b0, eff_bits}) begin
               // Fetch the next word; its data arrives in the next cycle.
               addr_in = addr_ff + IDX_W'(1);
               base_in = next_base[POS_W-1:0];
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ENCODE: begin
            // A match beyond the bits in use counts as not found.
            rsp_valid_in = 1'b1;
            if (hit_pos <= {1'b0, eff_bits}) begin
               rsp_found_in = 1'b1;
               rsp_num_in   = hit_pos[POS_W-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         fill_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         bits_in_use_ff <= POS_W'(MAX_BITS);
         start_clear_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_BITS_IN_USE: bits_in_use_ff <= csr_wdata;
               CSR_START_CLEAR: start_clear_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      want_one_ff  <= want_one_in;
      set_op_ff    <= set_op_in;
      addr_ff      <= addr_in;
      bit_ff       <= bit_in;
      base_ff      <= base_in;
      pos_ff       <= pos_in;
      match_ff     <= match_in;
      rsp_found_ff <= rsp_found_in;
      rsp_num_ff   <= rsp_num_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_bit_number = rsp_num_ff;

   // A result follows only an accepted request or a busy cycle.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(start && !busy) || $past(busy)))
      else $error("result transaction without a request");

   // A nonzero bit number is only reported as found.
   a_num_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_num_ff != '0)) |-> rsp_found_ff)
      else $error("bit number reported without found");

   // The encode cycle always ends the search with a result.
   a_encode_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENCODE) |=> rsp_valid_ff)
      else $error("search ended without a result");

   // The scan never walks past the bits in use.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (base_ff < eff_bits))
      else $error("scan beyond the bits in use");

endmodule

`default_nettype wire

// ===== rtl/core/bmff_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmff_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
